FILE: rtl/ssa_pkg.sv
`timescale 1ns / 1ps

package ssa_pkg;

    localparam int FUNC_W   = 2;
    localparam int SID_W    = 7;
    localparam int CONN_W   = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RSVD    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNLIC    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOCONN   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [CONN_W-1:0] CONN_MAX = 16'hffff;

    localparam logic CFG_MIN_IDLE = 1'b0;
    localparam logic CFG_LICENSED = 1'b1;

    typedef struct packed {
        logic take;     // idle age exceeds the threshold
        logic eldest;   // at least as old as the best so far
    } age_res_t;

endpackage

FILE: rtl/ssa_age_unit.sv
`timescale 1ns / 1ps

module ssa_age_unit
(
    input  logic [ssa_pkg::TIME_W-1:0] now_ms,
    input  logic [ssa_pkg::TIME_W-1:0] free_since,
    input  logic [ssa_pkg::TIME_W-1:0] min_idle,
    input  logic [ssa_pkg::TIME_W-1:0] best_age,
    input  logic                       best_set,
    output logic [ssa_pkg::TIME_W-1:0] age,
    output ssa_pkg::age_res_t          res
);
    import ssa_pkg::*;

    // age wraps modulo 2^32 with the clock
    assign age        = now_ms - free_since;
    assign res.take   = age > min_idle;
    assign res.eldest = !best_set || (age >= best_age);

endmodule

FILE: rtl/ssa_slot_mem.sv
`timescale 1ns / 1ps

module ssa_slot_mem #(
    parameter int DEPTH = 80,
    parameter int IDX_W = 7
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [IDX_W-1:0]           wr_addr,
    input  logic                       conn_we,
    input  logic [ssa_pkg::CONN_W-1:0] conn_wdata,
    input  logic                       free_we,
    input  logic [ssa_pkg::TIME_W-1:0] free_wdata,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic [ssa_pkg::CONN_W-1:0] conn_rdata,
    output logic [ssa_pkg::TIME_W-1:0] free_rdata
);
    import ssa_pkg::*;

    logic [CONN_W-1:0] conn_mem [DEPTH];
    logic [TIME_W-1:0] free_mem [DEPTH];
    logic [DEPTH-1:0]  free_valid_reg;
    logic [CONN_W-1:0] conn_rd_reg;
    logic [TIME_W-1:0] free_rd_reg;
    logic              free_rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (conn_we)
        begin
            conn_mem[wr_addr] <= conn_wdata;
        end
        if (free_we)
        begin
            free_mem[wr_addr] <= free_wdata;
        end
        conn_rd_reg <= conn_mem[rd_addr];
        free_rd_reg <= free_mem[rd_addr];
    end

    // free-since entries read as zero until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_valid_reg    <= '0;
            free_rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (free_we)
            begin
                free_valid_reg[wr_addr] <= 1'b1;
            end
            free_rd_valid_reg <= free_valid_reg[rd_addr];
        end
    end

    assign conn_rdata = conn_rd_reg;
    assign free_rdata = free_rd_valid_reg ? free_rd_reg : '0;

endmodule

FILE: rtl/session_slot_allocator.sv
`timescale 1ns / 1ps

// Channel | Dir | Fields (low bit up)
// s_*     | in  | tuser: func[1:0], is_utility[2]; tdata: session_id, connection_id, now_ms
// m_*     | out | tdata: status, out_session_id, out_connection_id
// cfg_*   | in  | index 0 min_idle_ms, index 1 regular_licensed
//
// One request at a time; s_tready is high only while the sequencer waits.
// Release: S_REL_RD reads the slot, then S_REL_WR writes it. Lookup: one slot table read per check.
// Allocate: regular search first, then each ID try scans all slots through the same
// table read port; at most ID_ATTEMPTS tries are made.
// Asynchronous reset clears the slot table state at once; the result register holds
// under m_tready low while the next request may already be taken.

module session_slot_allocator #(
    parameter int REGULAR_SESSIONS = 64,
    parameter int UTILITY_SESSIONS = 16,
    parameter int ID_ATTEMPTS      = 500
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // session_id[6:0], connection_id[22:7], now_ms[54:23]
    input  logic [2:0]  s_tuser,   // func[1:0], is_utility[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[2:0], out_session_id[9:3], out_connection_id[25:10]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import ssa_pkg::*;

    localparam int TOTAL = REGULAR_SESSIONS + UTILITY_SESSIONS;
    localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int RK_W  = (REGULAR_SESSIONS > 1) ? $clog2(REGULAR_SESSIONS) : 1;
    localparam int LP_W  = $clog2(REGULAR_SESSIONS + 1);
    localparam int ATT_W = $clog2(ID_ATTEMPTS + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOTAL - 1);
    localparam logic [IDX_W-1:0] REG_LAST = IDX_W'(REGULAR_SESSIONS - 1);
    localparam logic [IDX_W-1:0] UTIL_BASE = IDX_W'(REGULAR_SESSIONS % TOTAL);
    localparam logic [RK_W-1:0]  K_LAST   = RK_W'(REGULAR_SESSIONS - 1);
    localparam logic [ATT_W-1:0] ATT_MAX  = ATT_W'(ID_ATTEMPTS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RS_ADDR  = 4'd1;
    localparam logic [3:0] S_RS_CHK   = 4'd2;
    localparam logic [3:0] S_US       = 4'd3;
    localparam logic [3:0] S_BIND     = 4'd4;
    localparam logic [3:0] S_BS_ADDR  = 4'd5;
    localparam logic [3:0] S_BS_CHK   = 4'd6;
    localparam logic [3:0] S_REL_RD   = 4'd7;
    localparam logic [3:0] S_REL_WR   = 4'd8;
    localparam logic [3:0] S_LK_ADDR  = 4'd9;
    localparam logic [3:0] S_LK_CHK   = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [CONN_W-1:0]   cid_reg, cid_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    logic [RK_W-1:0]     k_reg, k_next;
    logic [TIME_W-1:0]   best_age_reg, best_age_next;
    logic                best_set_reg, best_set_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;
    logic [ATT_W-1:0]    att_reg, att_next;
    logic [CONN_W-1:0]   conn_counter_reg, conn_counter_next;
    logic [LP_W-1:0]     last_pick_reg, last_pick_next;
    logic [TOTAL-1:0]    busy_reg, busy_next;
    logic [TIME_W-1:0]   min_idle_reg;
    logic                licensed_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SID_W-1:0]    res_sid_reg, res_sid_next;
    logic [CONN_W-1:0]   res_cid_reg, res_cid_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SID_W-1:0]    out_sid_reg;
    logic [CONN_W-1:0]   out_cid_reg;

    logic [FUNC_W-1:0]   in_func;
    logic                in_util;
    logic [SID_W-1:0]    in_sid;
    logic [CONN_W-1:0]   in_cid;
    logic [TIME_W-1:0]   in_now;
    logic [IDX_W-1:0]    sid_idx;
    logic [IDX_W-1:0]    rs_start;
    logic [IDX_W-1:0]    rd_addr;
    logic                conn_we, free_we;
    logic [CONN_W-1:0]   conn_rdata;
    logic [TIME_W-1:0]   free_rdata;
    logic [TIME_W-1:0]   age;
    age_res_t            age_res;
    logic                rs_set;
    logic [IDX_W-1:0]    rs_idx;

    assign in_func = s_tuser[1:0];
    assign in_util = s_tuser[2];
    assign in_sid  = s_tdata[6:0];
    assign in_cid  = s_tdata[22:7];
    assign in_now  = s_tdata[54:23];
    assign sid_idx = IDX_W'(in_sid - 7'd1);
    assign rs_start = (last_pick_reg == '0 || last_pick_reg >= LP_W'(REGULAR_SESSIONS))
                      ? '0 : IDX_W'(last_pick_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign rd_addr  = (state_reg == S_REL_RD) ? pick_reg : scan_reg;

    ssa_slot_mem #(.DEPTH(TOTAL), .IDX_W(IDX_W)) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_addr    (pick_reg),
        .conn_we    (conn_we),
        .conn_wdata (conn_counter_reg),
        .free_we    (free_we),
        .free_wdata (now_reg),
        .rd_addr    (rd_addr),
        .conn_rdata (conn_rdata),
        .free_rdata (free_rdata)
    );

    ssa_age_unit u_age (
        .now_ms     (now_reg),
        .free_since (free_rdata),
        .min_idle   (min_idle_reg),
        .best_age   (best_age_reg),
        .best_set   (best_set_reg),
        .age        (age),
        .res        (age_res)
    );

    always_comb
    begin
        state_next        = state_reg;
        cid_next          = cid_reg;
        now_next          = now_reg;
        scan_next         = scan_reg;
        k_next            = k_reg;
        best_age_next     = best_age_reg;
        best_set_next     = best_set_reg;
        best_idx_next     = best_idx_reg;
        pick_next         = pick_reg;
        att_next          = att_reg;
        conn_counter_next = conn_counter_reg;
        last_pick_next    = last_pick_reg;
        busy_next         = busy_reg;
        res_status_next   = res_status_reg;
        res_sid_next      = res_sid_reg;
        res_cid_next      = res_cid_reg;
        conn_we           = 1'b0;
        free_we           = 1'b0;
        rs_set            = best_set_reg;
        rs_idx            = best_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cid_next        = in_cid;
                    now_next        = in_now;
                    res_status_next = ST_NOTFOUND;
                    res_sid_next    = '0;
                    res_cid_next    = '0;
                    state_next      = S_DONE;
                    case (in_func)
                        FUNC_ALLOC:
                        begin
                            if (in_util)
                            begin
                                if (UTILITY_SESSIONS == 0)
                                begin
                                    res_status_next = ST_NOSLOT;
                                end
                                else
                                begin
                                    scan_next  = UTIL_BASE;
                                    state_next = S_US;
                                end
                            end
                            else if (!licensed_reg)
                            begin
                                res_status_next = ST_UNLIC;
                            end
                            else
                            begin
                                scan_next     = rs_start;
                                k_next        = '0;
                                best_set_next = 1'b0;
                                state_next    = S_RS_ADDR;
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            if (in_sid != '0 && 32'(in_sid) <= TOTAL && busy_reg[sid_idx])
                            begin
                                pick_next  = sid_idx;
                                state_next = S_REL_RD;
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            if (in_cid != '0)
                            begin
                                scan_next  = '0;
                                state_next = S_LK_ADDR;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RS_ADDR, S_RS_CHK:
            begin
                if (state_reg == S_RS_ADDR && !busy_reg[scan_reg])
                begin
                    state_next = S_RS_CHK;
                end
                else if (state_reg == S_RS_CHK && age_res.take)
                begin
                    pick_next      = scan_reg;
                    last_pick_next = LP_W'(32'(scan_reg) + 32'd1);
                    att_next       = '0;
                    state_next     = S_BIND;
                end
                else
                begin
                    if (state_reg == S_RS_CHK && age_res.eldest)
                    begin
                        rs_set        = 1'b1;
                        rs_idx        = scan_reg;
                        best_set_next = 1'b1;
                        best_idx_next = scan_reg;
                        best_age_next = age;
                    end
                    if (k_reg == K_LAST)
                    begin
                        if (rs_set)
                        begin
                            pick_next      = rs_idx;
                            last_pick_next = LP_W'(32'(rs_idx) + 32'd1);
                            att_next       = '0;
                            state_next     = S_BIND;
                        end
                        else
                        begin
                            last_pick_next  = '0;
                            res_status_next = ST_NOSLOT;
                            state_next      = S_DONE;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        scan_next  = (scan_reg == REG_LAST) ? '0 : scan_reg + 1'b1;
                        state_next = S_RS_ADDR;
                    end
                end
            end
            S_US:
            begin
                if (!busy_reg[scan_reg])
                begin
                    pick_next  = scan_reg;
                    att_next   = '0;
                    state_next = S_BIND;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    res_status_next = ST_NOSLOT;
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_BIND:
            begin
                if (att_reg == ATT_MAX)
                begin
                    res_status_next = ST_NOCONN;
                    state_next      = S_DONE;
                end
                else
                begin
                    att_next          = att_reg + 1'b1;
                    conn_counter_next = (conn_counter_reg == CONN_MAX)
                                        ? CONN_W'(1) : conn_counter_reg + 1'b1;
                    scan_next         = '0;
                    state_next        = S_BS_ADDR;
                end
            end
            S_BS_ADDR, S_BS_CHK, S_LK_ADDR, S_LK_CHK:
            begin
                if ((state_reg == S_BS_ADDR || state_reg == S_LK_ADDR) && busy_reg[scan_reg])
                begin
                    // fetch the bound ID, compare next cycle
                    state_next = (state_reg == S_BS_ADDR) ? S_BS_CHK : S_LK_CHK;
                end
                else if (state_reg == S_BS_CHK && conn_rdata == conn_counter_reg)
                begin
                    state_next = S_BIND;
                end
                else if (state_reg == S_LK_CHK && conn_rdata == cid_reg)
                begin
                    res_status_next = ST_OK;
                    res_sid_next    = SID_W'(32'(scan_reg) + 32'd1);
                    res_cid_next    = cid_reg;
                    state_next      = S_DONE;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    state_next = S_DONE;
                    if (state_reg == S_BS_ADDR || state_reg == S_BS_CHK)
                    begin
                        conn_we             = 1'b1;
                        busy_next[pick_reg] = 1'b1;
                        res_status_next     = ST_OK;
                        res_sid_next        = SID_W'(32'(pick_reg) + 32'd1);
                        res_cid_next        = conn_counter_reg;
                    end
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = (state_reg == S_BS_ADDR || state_reg == S_BS_CHK)
                                 ? S_BS_ADDR : S_LK_ADDR;
                end
            end
            S_REL_RD:
            begin
                state_next = S_REL_WR;
            end
            S_REL_WR:
            begin
                free_we             = 1'b1;
                busy_next[pick_reg] = 1'b0;
                res_status_next     = ST_OK;
                res_sid_next        = SID_W'(32'(pick_reg) + 32'd1);
                res_cid_next        = conn_rdata;
                state_next          = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            conn_counter_reg <= '0;
            last_pick_reg    <= '0;
            busy_reg         <= '0;
            min_idle_reg     <= '0;
            licensed_reg     <= 1'b1;
            best_set_reg     <= 1'b0;
            att_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            conn_counter_reg <= conn_counter_next;
            last_pick_reg    <= last_pick_next;
            busy_reg         <= busy_next;
            best_set_reg     <= best_set_next;
            att_reg          <= att_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_MIN_IDLE)
                begin
                    min_idle_reg <= cfg_wdata;
                end
                else
                begin
                    licensed_reg <= cfg_wdata[0];
                end
            end
            if (state_reg == S_DONE && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cid_reg        <= cid_next;
        now_reg        <= now_next;
        scan_reg       <= scan_next;
        k_reg          <= k_next;
        best_age_reg   <= best_age_next;
        best_idx_reg   <= best_idx_next;
        pick_reg       <= pick_next;
        res_status_reg <= res_status_next;
        res_sid_reg    <= res_sid_next;
        res_cid_reg    <= res_cid_next;
        if (state_reg == S_DONE && (!out_valid_reg || m_tready))
        begin
            out_status_reg <= res_status_reg;
            out_sid_reg    <= res_sid_reg;
            out_cid_reg    <= res_cid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_cid_reg, out_sid_reg, out_status_reg};

`ifndef SYNTH
    a_ok_has_ids: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg == ST_OK) |-> (out_sid_reg != '0 && out_cid_reg != '0))
        else $error("ok result without session or connection ID");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg != ST_OK) |-> (out_sid_reg == '0 && out_cid_reg == '0))
        else $error("failed result carries IDs");

    a_att_bound: assert property (@(posedge clk) disable iff (!rst_n)
        att_reg <= ATT_MAX)
        else $error("ID try count past limit");

    a_bind_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        conn_we |=> busy_reg[$past(pick_reg)])
        else $error("bound slot not marked in use");
`endif

endmodule
